### rtl/core/fth_pkg.sv
`default_nettype none
package fth_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_ROLE_SERVER   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_RETRY_LIMIT   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_RETRY_TIMEOUT = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_HB_TIMEOUT    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_REMOTE_IP     = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_TARGET_PORT   = 3'd5;

   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_SYN     = 2'd1;
   localparam logic [1:0] PHASE_ACK     = 2'd2;
   localparam logic [1:0] PHASE_READY   = 2'd3;

   localparam logic       OP_TICK = 1'b0;
   localparam logic       OP_RECV = 1'b1;

   localparam logic [2:0] FLAG_SYN = 3'b100;
   localparam logic [2:0] FLAG_ACK = 3'b010;
   localparam logic [2:0] FLAG_PSH = 3'b001;

   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_PLAIN     = 2'd1;
   localparam logic [1:0] KIND_HEARTBEAT = 2'd2;

   localparam logic [3:0]  RESET_RETRY_LIMIT   = 4'd3;
   localparam logic [15:0] RESET_RETRY_TIMEOUT = 16'd1000;
   localparam logic [15:0] RESET_HB_TIMEOUT    = 16'd5000;

   typedef struct packed {
      logic        role_server;
      logic [3:0]  retry_limit;
      logic [15:0] retry_timeout_ms;
      logic [15:0] heartbeat_timeout_ms;
      logic [31:0] remote_ip;
      logic [15:0] target_port;
   } fth_cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] now_ms;
      logic        rx_syn;
      logic        rx_ack;
      logic [31:0] rx_src_ip;
      logic [15:0] rx_src_port;
      logic [31:0] rx_seq;
   } fth_item_type;

   typedef struct packed {
      logic        send_valid;
      logic        tx_syn;
      logic        tx_ack;
      logic        tx_psh;
      logic [31:0] tx_seq;
      logic [31:0] tx_ack_num;
      logic [31:0] tx_dst_ip;
      logic [15:0] tx_dst_port;
      logic        tx_heartbeat;
      logic [1:0]  conn_state;
   } fth_result_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [3:0]  retries_left;
      logic [31:0] phase_time;
      logic [31:0] heartbeat_time;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] local_seq;
      logic [31:0] ack_number;
      logic [2:0]  flag_bits;
   } fth_state_type;

endpackage
`default_nettype wire

### rtl/core/fth_channels.sv
`default_nettype none
interface fth_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] now_ms;
   logic        rx_syn;
   logic        rx_ack;
   logic [31:0] rx_src_ip;
   logic [15:0] rx_src_port;
   logic [31:0] rx_seq;

   modport source (output valid, opcode, now_ms, rx_syn, rx_ack, rx_src_ip, rx_src_port,
                   rx_seq, input ready);
   modport sink   (input valid, opcode, now_ms, rx_syn, rx_ack, rx_src_ip, rx_src_port,
                   rx_seq, output ready);
endinterface

interface fth_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_valid;
   logic        tx_syn;
   logic        tx_ack;
   logic        tx_psh;
   logic [31:0] tx_seq;
   logic [31:0] tx_ack_num;
   logic [31:0] tx_dst_ip;
   logic [15:0] tx_dst_port;
   logic        tx_heartbeat;
   logic [1:0]  conn_state;

   modport source (output valid, send_valid, tx_syn, tx_ack, tx_psh, tx_seq, tx_ack_num,
                   tx_dst_ip, tx_dst_port, tx_heartbeat, conn_state, input ready);
   modport sink   (input valid, send_valid, tx_syn, tx_ack, tx_psh, tx_seq, tx_ack_num,
                   tx_dst_ip, tx_dst_port, tx_heartbeat, conn_state, output ready);
endinterface
`default_nettype wire

### rtl/core/fth_fsm.sv
`default_nettype none
module fth_fsm (
   input  fth_pkg::fth_cfg_type    cfg,
   input  fth_pkg::fth_item_type   item,
   input  fth_pkg::fth_state_type  cur,
   output fth_pkg::fth_state_type  nxt,
   output fth_pkg::fth_result_type result
);
   import fth_pkg::*;

   logic [31:0] phase_elapsed;
   logic [31:0] hb_elapsed;
   logic        retry_expired;
   logic        hb_expired;
   logic        from_remote;
   logic        from_peer;
   logic [1:0]  kind;

   assign phase_elapsed = item.now_ms - cur.phase_time;
   assign hb_elapsed    = item.now_ms - cur.heartbeat_time;
   assign retry_expired = phase_elapsed > {16'd0, cfg.retry_timeout_ms};
   assign hb_expired    = hb_elapsed > {16'd0, cfg.heartbeat_timeout_ms};
   assign from_remote   = (item.rx_src_ip == cfg.remote_ip) &&
                          (item.rx_src_port == cfg.target_port);
   assign from_peer     = (item.rx_src_ip == cur.peer_ip) &&
                          (item.rx_src_port == cur.peer_port);

   always_comb begin
      nxt  = cur;
      kind = KIND_NONE;
      if (item.opcode == OP_TICK) begin
         if (!cfg.role_server) begin
            case (cur.phase)
               PHASE_IDLE: begin
                  nxt.local_seq    = '0;
                  nxt.ack_number   = '0;
                  nxt.flag_bits    = FLAG_SYN;
                  nxt.phase        = PHASE_SYN;
                  nxt.phase_time   = item.now_ms;
                  nxt.retries_left = cfg.retry_limit;
                  kind             = KIND_PLAIN;
               end
               PHASE_SYN, PHASE_ACK: begin
                  if (retry_expired) begin
                     nxt.phase_time = item.now_ms;
                     kind           = KIND_PLAIN;
                     if (cur.retries_left == 4'd0) begin
                        nxt.local_seq    = '0;
                        nxt.ack_number   = '0;
                        nxt.flag_bits    = FLAG_SYN;
                        nxt.phase        = PHASE_SYN;
                        nxt.retries_left = cfg.retry_limit;
                     end else begin
                        nxt.retries_left = cur.retries_left - 4'd1;
                        if (cur.phase == PHASE_SYN) begin
                           nxt.local_seq  = '0;
                           nxt.ack_number = '0;
                           nxt.flag_bits  = FLAG_SYN;
                        end
                     end
                  end
               end
               default: begin
                  if (hb_expired) begin
                     nxt.phase = PHASE_IDLE;
                  end else begin
                     nxt.flag_bits = (cur.flag_bits & FLAG_PSH) | FLAG_ACK;
                     kind          = KIND_HEARTBEAT;
                  end
               end
            endcase
         end else begin
            case (cur.phase)
               PHASE_IDLE: begin
                  kind = KIND_NONE;
               end
               PHASE_SYN: begin
                  if (retry_expired) begin
                     if (cur.retries_left == 4'd0) begin
                        nxt.phase = PHASE_IDLE;
                     end else begin
                        nxt.retries_left = cur.retries_left - 4'd1;
                        nxt.phase_time   = item.now_ms;
                        kind             = KIND_PLAIN;
                     end
                  end
               end
               default: begin
                  if (hb_expired) begin
                     nxt.phase = PHASE_IDLE;
                  end else begin
                     nxt.flag_bits = FLAG_ACK | FLAG_PSH;
                     kind          = KIND_HEARTBEAT;
                  end
               end
            endcase
         end
      end else begin
         if (!cfg.role_server) begin
            case (cur.phase)
               PHASE_SYN: begin
                  if (item.rx_syn && item.rx_ack && from_remote) begin
                     nxt.ack_number   = item.rx_seq + 32'd1;
                     nxt.flag_bits    = FLAG_ACK;
                     nxt.local_seq    = cur.local_seq + 32'd1;
                     nxt.phase        = PHASE_ACK;
                     nxt.phase_time   = item.now_ms;
                     nxt.retries_left = cfg.retry_limit;
                     kind             = KIND_PLAIN;
                  end
               end
               PHASE_ACK: begin
                  if (!item.rx_syn && item.rx_ack && from_remote) begin
                     nxt.phase          = PHASE_READY;
                     nxt.heartbeat_time = item.now_ms;
                  end
               end
               PHASE_READY: begin
                  nxt.heartbeat_time = item.now_ms;
               end
               default: begin
                  kind = KIND_NONE;
               end
            endcase
         end else begin
            case (cur.phase)
               PHASE_IDLE: begin
                  if (item.rx_syn && !item.rx_ack) begin
                     nxt.peer_ip      = item.rx_src_ip;
                     nxt.peer_port    = item.rx_src_port;
                     nxt.ack_number   = item.rx_seq + 32'd1;
                     nxt.flag_bits    = FLAG_SYN | FLAG_ACK;
                     nxt.phase        = PHASE_SYN;
                     nxt.retries_left = cfg.retry_limit;
                     nxt.phase_time   = item.now_ms;
                     kind             = KIND_PLAIN;
                  end
               end
               PHASE_SYN: begin
                  if (!item.rx_syn && item.rx_ack) begin
                     nxt.phase          = PHASE_ACK;
                     nxt.flag_bits      = (cur.flag_bits & FLAG_PSH) | FLAG_ACK;
                     nxt.heartbeat_time = item.now_ms;
                     nxt.phase_time     = item.now_ms;
                     kind               = KIND_HEARTBEAT;
                  end
               end
               default: begin
                  if (!item.rx_syn && item.rx_ack && from_peer) begin
                     if (cur.phase == PHASE_ACK) begin
                        nxt.phase      = PHASE_READY;
                        nxt.phase_time = item.now_ms;
                     end
                     nxt.heartbeat_time = item.now_ms;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      result            = '0;
      result.conn_state = nxt.phase;
      if (kind != KIND_NONE) begin
         result.send_valid   = 1'b1;
         result.tx_syn       = nxt.flag_bits[2];
         result.tx_ack       = nxt.flag_bits[1];
         result.tx_psh       = nxt.flag_bits[0];
         result.tx_seq       = nxt.local_seq;
         result.tx_ack_num   = nxt.ack_number;
         result.tx_dst_ip    = cfg.role_server ? nxt.peer_ip : cfg.remote_ip;
         result.tx_dst_port  = cfg.role_server ? nxt.peer_port : cfg.target_port;
         result.tx_heartbeat = (kind == KIND_HEARTBEAT);
      end
   end

endmodule
`default_nettype wire

### rtl/core/fake_tcp_handshake_keepalive_top.sv
`default_nettype none
// Connection state machine imitating a TCP three-way handshake with keepalive, as client or
// server. Each item (timer tick or parsed received segment, stamped with the millisecond time)
// gives exactly one result: the connection state after the item and at most one segment to
// send. An item is registered on entry, its whole update is computed combinationally from that
// register and the connection state, and the result is held in an output register; one item
// is accepted every cycle while the output is not stalled, and its result turns valid as the
// input register drains into the output register, while the output is empty or being taken.
// Configuration registers should be written only while no item is in flight.
module fake_tcp_handshake_keepalive_top (
   input  wire                                  clock,
   input  wire                                  reset,
   fth_req_if.sink                              req_chan,
   fth_rsp_if.source                            rsp_chan,
   input  wire                                  csr_wr_en,
   input  wire [fth_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire [fth_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import fth_pkg::*;

   fth_cfg_type    cfg_ff;
   fth_state_type  state_ff;
   fth_state_type  state_in;
   fth_item_type   item_ff;
   logic           item_vld_ff;
   fth_result_type result_in;
   fth_result_type result_ff;
   logic           result_vld_ff;
   logic           advance;
   logic           accept;

   assign advance        = item_vld_ff && (!result_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !item_vld_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.role_server          <= 1'b0;
         cfg_ff.retry_limit          <= RESET_RETRY_LIMIT;
         cfg_ff.retry_timeout_ms     <= RESET_RETRY_TIMEOUT;
         cfg_ff.heartbeat_timeout_ms <= RESET_HB_TIMEOUT;
         cfg_ff.remote_ip            <= '0;
         cfg_ff.target_port          <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROLE_SERVER:   cfg_ff.role_server          <= csr_wdata[0];
            CSR_RETRY_LIMIT:   cfg_ff.retry_limit          <= csr_wdata[3:0];
            CSR_RETRY_TIMEOUT: cfg_ff.retry_timeout_ms     <= csr_wdata[15:0];
            CSR_HB_TIMEOUT:    cfg_ff.heartbeat_timeout_ms <= csr_wdata[15:0];
            CSR_REMOTE_IP:     cfg_ff.remote_ip            <= csr_wdata[31:0];
            CSR_TARGET_PORT:   cfg_ff.target_port          <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.opcode      <= req_chan.opcode;
         item_ff.now_ms      <= req_chan.now_ms;
         item_ff.rx_syn      <= req_chan.rx_syn;
         item_ff.rx_ack      <= req_chan.rx_ack;
         item_ff.rx_src_ip   <= req_chan.rx_src_ip;
         item_ff.rx_src_port <= req_chan.rx_src_port;
         item_ff.rx_seq      <= req_chan.rx_seq;
      end
   end

   fth_fsm u_fsm (
      .cfg    (cfg_ff),
      .item   (item_ff),
      .cur    (state_ff),
      .nxt    (state_in),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_vld_ff <= 1'b0;
      end else if (advance) begin
         result_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         result_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid        = result_vld_ff;
   assign rsp_chan.send_valid   = result_ff.send_valid;
   assign rsp_chan.tx_syn       = result_ff.tx_syn;
   assign rsp_chan.tx_ack       = result_ff.tx_ack;
   assign rsp_chan.tx_psh       = result_ff.tx_psh;
   assign rsp_chan.tx_seq       = result_ff.tx_seq;
   assign rsp_chan.tx_ack_num   = result_ff.tx_ack_num;
   assign rsp_chan.tx_dst_ip    = result_ff.tx_dst_ip;
   assign rsp_chan.tx_dst_port  = result_ff.tx_dst_port;
   assign rsp_chan.tx_heartbeat = result_ff.tx_heartbeat;
   assign rsp_chan.conn_state   = result_ff.conn_state;

endmodule
`default_nettype wire

### dv/fake_tcp_handshake_keepalive_top_tb.sv
`timescale 1ns / 1ps

module fake_tcp_handshake_keepalive_top_tb;
   import fth_pkg::*;

   class session_scoreboard;
      logic        role          = 1'b0;
      logic [3:0]  retry_limit   = RESET_RETRY_LIMIT;
      logic [15:0] retry_to      = RESET_RETRY_TIMEOUT;
      logic [15:0] hb_to         = RESET_HB_TIMEOUT;
      logic [31:0] remote_ip     = '0;
      logic [15:0] target_port   = '0;
      logic [1:0]  phase         = PHASE_IDLE;
      logic [3:0]  retries       = '0;
      logic [31:0] phase_time    = '0;
      logic [31:0] hb_time       = '0;
      logic [31:0] peer_ip       = '0;
      logic [15:0] peer_port     = '0;
      logic [31:0] local_seq     = '0;
      logic [31:0] ack_number    = '0;
      logic [2:0]  flags         = '0;
      fth_result_type expected_segments[$];
      int mismatches    = 0;
      int checked       = 0;
      int sends         = 0;
      int heartbeats    = 0;
      int ready_entries = 0;

      function void set_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_ROLE_SERVER:   role = data[0];
            CSR_RETRY_LIMIT:   retry_limit = data[3:0];
            CSR_RETRY_TIMEOUT: retry_to = data[15:0];
            CSR_HB_TIMEOUT:    hb_to = data[15:0];
            CSR_REMOTE_IP:     remote_ip = data;
            CSR_TARGET_PORT:   target_port = data[15:0];
            default: ;
         endcase
      endfunction

      function bit expired(logic [31:0] now, logic [31:0] stamp, logic [15:0] lim);
         logic [31:0] elapsed;
         elapsed = now - stamp;
         return elapsed > {16'd0, lim};
      endfunction

      function void load_syn();
         local_seq = '0;
         ack_number = '0;
         flags = FLAG_SYN;
      endfunction

      function void advance_session(fth_item_type it);
         logic [1:0]     kind;
         logic [1:0]     was;
         logic           from_remote;
         logic           from_peer;
         fth_result_type r;
         kind = KIND_NONE;
         was = phase;
         from_remote = (it.rx_src_ip == remote_ip) && (it.rx_src_port == target_port);
         from_peer = (it.rx_src_ip == peer_ip) && (it.rx_src_port == peer_port);
         if (it.opcode == OP_TICK && !role) begin
            if (phase == PHASE_IDLE) begin
               load_syn();
               phase = PHASE_SYN;
               phase_time = it.now_ms;
               retries = retry_limit;
               kind = KIND_PLAIN;
            end else if (phase == PHASE_SYN || phase == PHASE_ACK) begin
               if (expired(it.now_ms, phase_time, retry_to)) begin
                  if (retries == 0) begin
                     load_syn();
                     phase = PHASE_SYN;
                     retries = retry_limit;
                  end else begin
                     retries = retries - 4'd1;
                     if (phase == PHASE_SYN) load_syn();
                  end
                  phase_time = it.now_ms;
                  kind = KIND_PLAIN;
               end
            end else if (expired(it.now_ms, hb_time, hb_to)) begin
               phase = PHASE_IDLE;
            end else begin
               flags = (flags & FLAG_PSH) | FLAG_ACK;
               kind = KIND_HEARTBEAT;
            end
         end else if (it.opcode == OP_TICK) begin
            if (phase == PHASE_SYN) begin
               if (expired(it.now_ms, phase_time, retry_to)) begin
                  if (retries == 0) begin
                     phase = PHASE_IDLE;
                  end else begin
                     retries = retries - 4'd1;
                     phase_time = it.now_ms;
                     kind = KIND_PLAIN;
                  end
               end
            end else if (phase != PHASE_IDLE) begin
               if (expired(it.now_ms, hb_time, hb_to)) begin
                  phase = PHASE_IDLE;
               end else begin
                  flags = FLAG_ACK | FLAG_PSH;
                  kind = KIND_HEARTBEAT;
               end
            end
         end else if (!role) begin
            case (phase)
               PHASE_SYN: begin
                  if (it.rx_syn && it.rx_ack && from_remote) begin
                     ack_number = it.rx_seq + 32'd1;
                     flags = FLAG_ACK;
                     local_seq = local_seq + 32'd1;
                     phase = PHASE_ACK;
                     phase_time = it.now_ms;
                     retries = retry_limit;
                     kind = KIND_PLAIN;
                  end
               end
               PHASE_ACK: begin
                  if (!it.rx_syn && it.rx_ack && from_remote) begin
                     phase = PHASE_READY;
                     hb_time = it.now_ms;
                  end
               end
               PHASE_READY: hb_time = it.now_ms;
               default: ;
            endcase
         end else begin
            case (phase)
               PHASE_IDLE: begin
                  if (it.rx_syn && !it.rx_ack) begin
                     peer_ip = it.rx_src_ip;
                     peer_port = it.rx_src_port;
                     ack_number = it.rx_seq + 32'd1;
                     flags = FLAG_SYN | FLAG_ACK;
                     phase = PHASE_SYN;
                     retries = retry_limit;
                     phase_time = it.now_ms;
                     kind = KIND_PLAIN;
                  end
               end
               PHASE_SYN: begin
                  if (!it.rx_syn && it.rx_ack) begin
                     phase = PHASE_ACK;
                     flags = (flags & FLAG_PSH) | FLAG_ACK;
                     hb_time = it.now_ms;
                     phase_time = it.now_ms;
                     kind = KIND_HEARTBEAT;
                  end
               end
               default: begin
                  if (!it.rx_syn && it.rx_ack && from_peer) begin
                     if (phase == PHASE_ACK) begin
                        phase = PHASE_READY;
                        phase_time = it.now_ms;
                     end
                     hb_time = it.now_ms;
                  end
               end
            endcase
         end
         if (phase == PHASE_READY && was != PHASE_READY) ready_entries++;
         r = '0;
         if (kind != KIND_NONE) begin
            r.send_valid   = 1'b1;
            r.tx_syn       = flags[2];
            r.tx_ack       = flags[1];
            r.tx_psh       = flags[0];
            r.tx_seq       = local_seq;
            r.tx_ack_num   = ack_number;
            r.tx_dst_ip    = role ? peer_ip : remote_ip;
            r.tx_dst_port  = role ? peer_port : target_port;
            r.tx_heartbeat = (kind == KIND_HEARTBEAT);
            sends++;
            if (kind == KIND_HEARTBEAT) heartbeats++;
         end
         r.conn_state = phase;
         expected_segments.push_back(r);
      endfunction

      function void check_segment(fth_result_type got);
         fth_result_type want;
         string          diff;
         checked++;
         if (expected_segments.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result %0d with nothing expected: %h", checked, got);
            return;
         end
         want = expected_segments.pop_front();
         diff = "";
         if (got.send_valid !== want.send_valid)
            diff = {diff, $sformatf(" send_valid %b/%b", want.send_valid, got.send_valid)};
         if (got.tx_syn !== want.tx_syn)
            diff = {diff, $sformatf(" tx_syn %b/%b", want.tx_syn, got.tx_syn)};
         if (got.tx_ack !== want.tx_ack)
            diff = {diff, $sformatf(" tx_ack %b/%b", want.tx_ack, got.tx_ack)};
         if (got.tx_psh !== want.tx_psh)
            diff = {diff, $sformatf(" tx_psh %b/%b", want.tx_psh, got.tx_psh)};
         if (got.tx_seq !== want.tx_seq)
            diff = {diff, $sformatf(" tx_seq %h/%h", want.tx_seq, got.tx_seq)};
         if (got.tx_ack_num !== want.tx_ack_num)
            diff = {diff, $sformatf(" tx_ack_num %h/%h", want.tx_ack_num, got.tx_ack_num)};
         if (got.tx_dst_ip !== want.tx_dst_ip)
            diff = {diff, $sformatf(" tx_dst_ip %h/%h", want.tx_dst_ip, got.tx_dst_ip)};
         if (got.tx_dst_port !== want.tx_dst_port)
            diff = {diff, $sformatf(" tx_dst_port %h/%h", want.tx_dst_port, got.tx_dst_port)};
         if (got.tx_heartbeat !== want.tx_heartbeat)
            diff = {diff, $sformatf(" tx_heartbeat %b/%b", want.tx_heartbeat, got.tx_heartbeat)};
         if (got.conn_state !== want.conn_state)
            diff = {diff, $sformatf(" conn_state %0d/%0d", want.conn_state, got.conn_state)};
         if (diff != "") begin
            mismatches++;
            if (mismatches <= 10) $display("result %0d wrong (expected/actual):%s", checked, diff);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   fth_req_if req_chan();
   fth_rsp_if rsp_chan();

   fake_tcp_handshake_keepalive_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   session_scoreboard sb;
   logic [31:0]       clock_ms;
   bit                req_steady;
   bit                rsp_steady;
   int                items_sent;
   int                settings_run;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic fth_item_type make_item(logic op, logic [31:0] now, logic syn, logic ack,
                                              logic [31:0] ip, logic [15:0] port,
                                              logic [31:0] seq);
      fth_item_type it;
      it.opcode      = op;
      it.now_ms      = now;
      it.rx_syn      = syn;
      it.rx_ack      = ack;
      it.rx_src_ip   = ip;
      it.rx_src_port = port;
      it.rx_seq      = seq;
      return it;
   endfunction

   // mostly items that move the session on, with some noise
   function automatic fth_item_type next_stimulus();
      int          pick;
      logic        op;
      logic        syn;
      logic        ack;
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] stamp;
      logic [31:0] span;
      logic [31:0] now;
      ip   = sb.role ? sb.peer_ip : sb.remote_ip;
      port = sb.role ? sb.peer_port : sb.target_port;
      syn  = 1'($urandom_range(0, 1));
      ack  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         op = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 2))
            0: begin
               ip   = $urandom;
               port = 16'($urandom_range(0, 65535));
            end
            1: ip = ip ^ (32'd1 << $urandom_range(0, 31));
            default: port = port ^ (16'd1 << $urandom_range(0, 15));
         endcase
      end else begin
         pick = $urandom_range(0, 99);
         case ({sb.role, sb.phase})
            {1'b0, PHASE_IDLE}: op = OP_TICK;
            {1'b0, PHASE_SYN}: begin
               op  = (pick < 60) ? OP_RECV : OP_TICK;
               syn = 1'b1;
               ack = 1'b1;
            end
            {1'b0, PHASE_ACK}: begin
               op  = (pick < 60) ? OP_RECV : OP_TICK;
               syn = 1'b0;
               ack = 1'b1;
            end
            {1'b0, PHASE_READY}: begin
               op = (pick < 70) ? OP_TICK : OP_RECV;
               ip = $urandom;
            end
            {1'b1, PHASE_IDLE}: begin
               op   = (pick < 80) ? OP_RECV : OP_TICK;
               syn  = 1'b1;
               ack  = 1'b0;
               ip   = $urandom;
               port = 16'($urandom_range(0, 65535));
            end
            {1'b1, PHASE_SYN}: begin
               op  = (pick < 60) ? OP_RECV : OP_TICK;
               syn = 1'b0;
               ack = 1'b1;
               if ($urandom_range(0, 1)) ip = $urandom;
            end
            default: begin
               op  = (pick < ((sb.phase == PHASE_ACK) ? 70 : 40)) ? OP_RECV : OP_TICK;
               syn = 1'b0;
               ack = 1'b1;
            end
         endcase
         if (op == OP_TICK) begin
            ip   = $urandom;
            port = 16'($urandom_range(0, 65535));
         end
      end
      if (sb.phase == PHASE_READY || (sb.role && sb.phase == PHASE_ACK)) begin
         stamp = sb.hb_time;
         span  = {16'd0, sb.hb_to};
      end else begin
         stamp = sb.phase_time;
         span  = {16'd0, sb.retry_to};
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)      now = clock_ms + $urandom_range(0, span / 2);
      else if (pick < 80) now = stamp + span + $urandom_range(0, 1);
      else if (pick < 95) now = clock_ms + $urandom_range(0, 3 * span + 3);
      else                now = $urandom;
      clock_ms = now;
      return make_item(op, now, syn, ack, ip, port, $urandom);
   endfunction

   task automatic send_item(fth_item_type it);
      int gap;
      if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= it.opcode;
      req_chan.now_ms      <= it.now_ms;
      req_chan.rx_syn      <= it.rx_syn;
      req_chan.rx_ack      <= it.rx_ack;
      req_chan.rx_src_ip   <= it.rx_src_ip;
      req_chan.rx_src_port <= it.rx_src_port;
      req_chan.rx_seq      <= it.rx_seq;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.advance_session(it);
      items_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.expected_segments.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic put_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic apply_setting(logic role, logic [3:0] lim, logic [15:0] rto,
                                logic [15:0] hbto, logic [31:0] ip, logic [15:0] port);
      drain();
      put_reg(CSR_ROLE_SERVER, {31'd0, role});
      put_reg(CSR_RETRY_LIMIT, {28'd0, lim});
      put_reg(CSR_RETRY_TIMEOUT, {16'd0, rto});
      put_reg(CSR_HB_TIMEOUT, {16'd0, hbto});
      put_reg(CSR_REMOTE_IP, ip);
      put_reg(CSR_TARGET_PORT, {16'd0, port});
      csr_wr_en <= 1'b0;
      settings_run++;
   endtask

   task automatic take_results();
      fth_result_type got;
      int             stall;
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         got.send_valid   = rsp_chan.send_valid;
         got.tx_syn       = rsp_chan.tx_syn;
         got.tx_ack       = rsp_chan.tx_ack;
         got.tx_psh       = rsp_chan.tx_psh;
         got.tx_seq       = rsp_chan.tx_seq;
         got.tx_ack_num   = rsp_chan.tx_ack_num;
         got.tx_dst_ip    = rsp_chan.tx_dst_ip;
         got.tx_dst_port  = rsp_chan.tx_dst_port;
         got.tx_heartbeat = rsp_chan.tx_heartbeat;
         got.conn_state   = rsp_chan.conn_state;
         sb.check_segment(got);
      end
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 59) == 0) drain();
         send_item(next_stimulus());
      end
   endtask

   initial begin
      int p;
      int wait_cycles;
      sb = new;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = OP_TICK;
      req_chan.now_ms      = '0;
      req_chan.rx_syn      = 1'b0;
      req_chan.rx_ack      = 1'b0;
      req_chan.rx_src_ip   = '0;
      req_chan.rx_src_port = '0;
      req_chan.rx_seq      = '0;
      rsp_chan.ready       = 1'b0;
      clock_ms             = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      fork
         take_results();
      join_none

      // client walk-through: retries, give-up restart, wrap of the clock, keepalive expiry
      apply_setting(1'b0, 4'd1, 16'd10, 16'd20, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(make_item(OP_TICK, 32'hFFFF_FFF0, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_TICK, 32'hFFFF_FFFA, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_TICK, 32'hFFFF_FFFB, 1'b1, 1'b1, '1, '1, '1));
      send_item(make_item(OP_TICK, 32'd5, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_TICK, 32'd6, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_RECV, 32'd6, 1'b1, 1'b1, 32'hFFFF_FFFE, 16'hFFFF, '0));
      send_item(make_item(OP_RECV, 32'd6, 1'b1, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, '0));
      send_item(make_item(OP_RECV, 32'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, '1));
      send_item(make_item(OP_TICK, 32'd18, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_RECV, 32'd19, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, '0));
      send_item(make_item(OP_RECV, 32'd20, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, '0));
      send_item(make_item(OP_TICK, 32'd30, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_RECV, 32'd35, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_TICK, 32'd55, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_TICK, 32'd56, 1'b0, 1'b0, '0, '0, '0));

      // server walk-through: give-up to idle, ack from any source, peer filtering
      apply_setting(1'b1, 4'd1, 16'd10, 16'd20, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(make_item(OP_TICK, 32'd100, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_RECV, 32'd100, 1'b1, 1'b1, '0, '0, '0));
      send_item(make_item(OP_RECV, 32'd100, 1'b1, 1'b0, '0, '0, '0));
      send_item(make_item(OP_TICK, 32'd111, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_TICK, 32'd122, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_RECV, 32'd200, 1'b1, 1'b0, 32'hA5A5_5A5A, 16'd1234, 32'h8000_0000));
      send_item(make_item(OP_RECV, 32'd205, 1'b0, 1'b1, '0, '0, '0));
      send_item(make_item(OP_RECV, 32'd207, 1'b0, 1'b1, 32'hA5A5_5A5B, 16'd1234, '0));
      send_item(make_item(OP_RECV, 32'd210, 1'b0, 1'b1, 32'hA5A5_5A5A, 16'd1234, '0));
      send_item(make_item(OP_TICK, 32'd215, 1'b0, 1'b0, '0, '0, '0));
      send_item(make_item(OP_TICK, 32'd231, 1'b0, 1'b0, '0, '0, '0));

      for (p = 0; p < 8; p++) begin
         case (p)
            0: apply_setting(1'b0, 4'd3, 16'd1000, 16'd5000, $urandom,
                             16'($urandom_range(0, 65535)));
            1: apply_setting(1'b0, 4'd0, 16'd1, 16'd1, 32'hFFFF_FFFF, 16'hFFFF);
            2: apply_setting(1'b1, 4'd15, 16'hFFFF, 16'hFFFF, '0, '0);
            3: apply_setting(1'b1, 4'd0, 16'd1, 16'd1, $urandom,
                             16'($urandom_range(0, 65535)));
            4: apply_setting(1'b0, 4'd15, 16'hFFFF, 16'hFFFF, '0, '0);
            5: apply_setting(1'b1, 4'($urandom_range(0, 15)), 16'($urandom_range(1, 300)),
                             16'($urandom_range(1, 3000)), $urandom,
                             16'($urandom_range(0, 65535)));
            6: apply_setting(1'b0, 4'($urandom_range(0, 15)), 16'($urandom_range(1, 300)),
                             16'($urandom_range(1, 3000)), $urandom,
                             16'($urandom_range(0, 65535)));
            default: apply_setting(1'b1, 4'd3, 16'($urandom_range(1, 65535)),
                                   16'($urandom_range(1, 65535)), $urandom,
                                   16'($urandom_range(0, 65535)));
         endcase
         run_random(190);
      end

      req_chan.valid <= 1'b0;
      wait_cycles = 0;
      while (sb.expected_segments.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4) @(posedge clock);

      $display("%0d items under %0d register settings, %0d results checked",
               items_sent, settings_run, sb.checked);
      $display("%0d segments sent, %0d of them heartbeats, ready state entered %0d times",
               sb.sends, sb.heartbeats, sb.ready_entries);
      if (sb.mismatches == 0 && sb.expected_segments.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches,
                  sb.expected_segments.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule
